[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the pulse meter rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// next-cycle implication, disabled during reset
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

[design/pdrm_pkg.sv]
// ----------------------------------------------------------------------------
// pdrm_pkg
// shared types, constants and register map of the pulse rate / duty meter
// ----------------------------------------------------------------------------
package pdrm_pkg;

	// counter and field widths
	localparam int CNT_W    = 16;
	localparam int LIMIT_W  = 16;
	localparam int RATE_W   = 16;
	localparam int DUTY_W   = 11;
	localparam int SCALE_W  = 11;
	localparam int OFS_W    = 8;
	localparam int PROD_W   = CNT_W + SCALE_W;
	localparam int SUM_W    = CNT_W + 1;
	localparam int REM_W    = SUM_W + 1;
	localparam int QUO_W    = SCALE_W;
	localparam int DIV_STEPS = QUO_W;
	localparam int STEP_W   = $clog2(DIV_STEPS);

	// bus widths
	localparam int PADDR_W  = 5;
	localparam int PDATA_W  = 32;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 32;

	// register indexes (paddr[4:2])
	localparam logic [2:0] REG_MODE    = 3'd0;
	localparam logic [2:0] REG_PHASE   = 3'd1;
	localparam logic [2:0] REG_SILENCE = 3'd2;
	localparam logic [2:0] REG_WINDOW  = 3'd3;
	localparam logic [2:0] REG_SCALE   = 3'd4;
	localparam logic [2:0] REG_OFFSET  = 3'd5;

	// reset values
	localparam logic [LIMIT_W-1:0] PHASE_LIMIT_RST   = 16'd60000;
	localparam logic [LIMIT_W-1:0] SILENCE_LIMIT_RST = 16'd15000;
	localparam logic [LIMIT_W-1:0] WINDOW_TICKS_RST  = 16'd999;
	localparam logic [SCALE_W-1:0] DUTY_SCALE_RST    = 11'd1100;
	localparam logic [OFS_W-1:0]   DUTY_OFFSET_RST   = 8'd25;

	// item kinds
	localparam logic ITEM_TICK = 1'b0;
	localparam logic ITEM_EDGE = 1'b1;
	localparam logic MODE_PULSE = 1'b0;
	localparam logic MODE_CYCLE = 1'b1;

	typedef struct packed {
		logic               measure_mode;
		logic [LIMIT_W-1:0] phase_limit;
		logic [LIMIT_W-1:0] silence_limit;
		logic [LIMIT_W-1:0] window_ticks;
		logic [SCALE_W-1:0] duty_scale;
		logic [OFS_W-1:0]   duty_offset;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_LOAD,
		ST_DIV,
		ST_FIN,
		ST_EMIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // input transaction taken, apply tick or edge
		logic mul;       // register product and phase sum
		logic div_init;  // seed the divider
		logic div_step;  // one restoring division step
		logic fin;       // apply offset and clamp, update duty latch
		logic emit;      // load output register
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic duty_edge; // current input is a falling edge in cycle mode
		logic sum_zero;  // high plus low phase is zero
	} ctl_stat_t;

endpackage

[design/pdrm_regs.sv]
// ----------------------------------------------------------------------------
// pdrm_regs
// apb configuration register file
// ----------------------------------------------------------------------------
module pdrm_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [pdrm_pkg::PADDR_W-1:0] paddr,
	input  logic [pdrm_pkg::PDATA_W-1:0] pwdata,
	output logic [pdrm_pkg::PDATA_W-1:0] prdata,
	output logic                         pready,
	output pdrm_pkg::cfg_t               cfg
);
	import pdrm_pkg::*;

	cfg_t       cfg_q;
	logic [2:0] idx;
	logic       wr_en;

	assign idx    = paddr[4:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.measure_mode  <= MODE_PULSE;
			cfg_q.phase_limit   <= PHASE_LIMIT_RST;
			cfg_q.silence_limit <= SILENCE_LIMIT_RST;
			cfg_q.window_ticks  <= WINDOW_TICKS_RST;
			cfg_q.duty_scale    <= DUTY_SCALE_RST;
			cfg_q.duty_offset   <= DUTY_OFFSET_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_MODE:    cfg_q.measure_mode  <= pwdata[0];
				REG_PHASE:   cfg_q.phase_limit   <= pwdata[LIMIT_W-1:0];
				REG_SILENCE: cfg_q.silence_limit <= pwdata[LIMIT_W-1:0];
				REG_WINDOW:  cfg_q.window_ticks  <= pwdata[LIMIT_W-1:0];
				REG_SCALE:   cfg_q.duty_scale    <= pwdata[SCALE_W-1:0];
				REG_OFFSET:  cfg_q.duty_offset   <= pwdata[OFS_W-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_MODE:    prdata = {{(PDATA_W-1){1'b0}}, cfg_q.measure_mode};
			REG_PHASE:   prdata = {{(PDATA_W-LIMIT_W){1'b0}}, cfg_q.phase_limit};
			REG_SILENCE: prdata = {{(PDATA_W-LIMIT_W){1'b0}}, cfg_q.silence_limit};
			REG_WINDOW:  prdata = {{(PDATA_W-LIMIT_W){1'b0}}, cfg_q.window_ticks};
			REG_SCALE:   prdata = {{(PDATA_W-SCALE_W){1'b0}}, cfg_q.duty_scale};
			REG_OFFSET:  prdata = {{(PDATA_W-OFS_W){1'b0}}, cfg_q.duty_offset};
			default:     prdata = '0;
		endcase
	end

endmodule

[design/pdrm_ctrl.sv]
// ----------------------------------------------------------------------------
// pdrm_ctrl
// sequencing state machine: item intake, multiply, serial divide, result out
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pdrm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  pdrm_pkg::ctl_stat_t stat,
	output pdrm_pkg::ctl_cmd_t  cmd
);
	import pdrm_pkg::*;

	state_t            state_q;
	state_t            state_d;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	logic              out_free;
	logic              accept;
	logic              last_step;

	assign out_free  = !out_valid_q || out_ready;
	assign accept    = in_valid && (state_q == ST_IDLE);
	assign last_step = (step_q == STEP_W'(DIV_STEPS - 1));
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) begin
				state_d = stat.duty_edge ? ST_MUL : ST_EMIT;
			end
			ST_MUL:  state_d = stat.sum_zero ? ST_EMIT : ST_LOAD;
			ST_LOAD: state_d = ST_DIV;
			ST_DIV:  if (last_step) begin
				state_d = ST_FIN;
			end
			ST_FIN:  state_d = ST_EMIT;
			ST_EMIT: if (out_free) begin
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd          = '0;
		cmd.load     = accept;
		cmd.mul      = (state_q == ST_MUL);
		cmd.div_init = (state_q == ST_LOAD);
		cmd.div_step = (state_q == ST_DIV);
		cmd.fin      = (state_q == ST_FIN);
		cmd.emit     = (state_q == ST_EMIT) && out_free;
	end

	// state, step counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_LOAD) begin
				step_q <= '0;
			end else if (state_q == ST_DIV) begin
				step_q <= step_q + 1'b1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`ASSERT_NXT(a_plain_item_to_emit, clk, arst_n, accept && !stat.duty_edge, state_q == ST_EMIT)
	`ASSERT_IMP(a_step_in_range, clk, arst_n, state_q == ST_DIV, step_q < STEP_W'(DIV_STEPS))
	`ASSERT_NXT(a_emit_sets_valid, clk, arst_n, cmd.emit, out_valid_q)

endmodule

[design/pdrm_dp.sv]
// ----------------------------------------------------------------------------
// pdrm_dp
// measurement datapath: tick counters, latches, multiplier and serial divider
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pdrm_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  pdrm_pkg::cfg_t                   cfg,
	input  pdrm_pkg::ctl_cmd_t               cmd,
	output pdrm_pkg::ctl_stat_t              stat,
	input  logic                             in_cmd,
	input  logic                             in_level,
	output logic [pdrm_pkg::RATE_W-1:0]      out_rate,
	output logic [pdrm_pkg::DUTY_W-1:0]      out_duty
);
	import pdrm_pkg::*;

	// measurement state
	logic [CNT_W-1:0]  phase_ticks_q;
	logic [CNT_W-1:0]  silence_ticks_q;
	logic [CNT_W-1:0]  window_count_q;
	logic [RATE_W-1:0] edge_count_q;
	logic [CNT_W-1:0]  low_phase_q;
	logic [CNT_W-1:0]  high_phase_q;
	logic [RATE_W-1:0] rate_latch_q;
	logic [DUTY_W-1:0] duty_latch_q;

	// divider state
	logic [PROD_W-1:0] prod_q;
	logic [SUM_W-1:0]  sum_q;
	logic [SUM_W-1:0]  rem_q;
	logic [QUO_W-1:0]  quo_q;

	// output register
	logic [RATE_W-1:0] out_rate_q;
	logic [DUTY_W-1:0] out_duty_q;

	logic [CNT_W-1:0]  ph_inc;
	logic [CNT_W-1:0]  si_inc;
	logic [CNT_W-1:0]  wi_inc;
	logic              ph_over;
	logic              si_over;
	logic              win_hit;
	logic [REM_W-1:0]  rem_sh;
	logic [REM_W-1:0]  rem_sub;
	logic              q_bit;
	logic [DUTY_W-1:0] duty_fin;
	logic              tick_load;
	logic              edge_load;

	// tick counter increments and limit checks
	assign ph_inc  = phase_ticks_q + 1'b1;
	assign si_inc  = silence_ticks_q + 1'b1;
	assign wi_inc  = window_count_q + 1'b1;
	assign ph_over = ph_inc > cfg.phase_limit;
	assign si_over = si_inc > cfg.silence_limit;
	assign win_hit = wi_inc >= cfg.window_ticks;

	// kind of the transaction being applied
	assign tick_load = cmd.load && (in_cmd == ITEM_TICK);
	assign edge_load = cmd.load && (in_cmd == ITEM_EDGE);

	// status to the controller
	assign stat.duty_edge = (in_cmd == ITEM_EDGE) && !in_level
		&& (cfg.measure_mode == MODE_CYCLE);
	assign stat.sum_zero  = (high_phase_q == '0) && (low_phase_q == '0);

	// restoring division step
	assign rem_sh  = {rem_q, quo_q[QUO_W-1]};
	assign rem_sub = rem_sh - {1'b0, sum_q};
	assign q_bit   = !rem_sub[REM_W-1];

	// offset and clamp on the quotient
	assign duty_fin = (quo_q > {{(QUO_W-OFS_W){1'b0}}, cfg.duty_offset})
		? DUTY_W'(quo_q - {{(QUO_W-OFS_W){1'b0}}, cfg.duty_offset}) : '0;

	// tick and edge updates, duty latch update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q   <= '0;
			silence_ticks_q <= '0;
			window_count_q  <= '0;
			edge_count_q    <= '0;
			low_phase_q     <= '0;
			high_phase_q    <= '0;
			rate_latch_q    <= '0;
			duty_latch_q    <= '0;
		end else if (cmd.load) begin
			if (in_cmd == ITEM_TICK) begin
				phase_ticks_q   <= ph_over ? '0 : ph_inc;
				silence_ticks_q <= si_over ? '0 : si_inc;
				if (ph_over || si_over) begin
					duty_latch_q <= '0;
				end
				if (win_hit) begin
					rate_latch_q   <= edge_count_q;
					edge_count_q   <= '0;
					window_count_q <= '0;
				end else begin
					window_count_q <= wi_inc;
					if (si_over) begin
						rate_latch_q <= '0;
					end
				end
			end else begin
				silence_ticks_q <= '0;
				if (cfg.measure_mode == MODE_PULSE) begin
					if (edge_count_q != '1) begin
						edge_count_q <= edge_count_q + 1'b1;
					end
				end else if (in_level) begin
					low_phase_q   <= phase_ticks_q;
					phase_ticks_q <= '0;
				end else begin
					high_phase_q  <= phase_ticks_q;
					phase_ticks_q <= '0;
				end
			end
		end else if (cmd.fin) begin
			duty_latch_q <= duty_fin;
		end
	end

	// multiplier and serial divider
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q <= PROD_W'(high_phase_q) * PROD_W'(cfg.duty_scale);
			sum_q  <= SUM_W'(high_phase_q) + SUM_W'(low_phase_q);
		end
		if (cmd.div_init) begin
			rem_q <= SUM_W'(prod_q[PROD_W-1:QUO_W]);
			quo_q <= prod_q[QUO_W-1:0];
		end else if (cmd.div_step) begin
			rem_q <= q_bit ? rem_sub[SUM_W-1:0] : rem_sh[SUM_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], q_bit};
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_rate_q <= rate_latch_q;
			out_duty_q <= duty_latch_q;
		end
	end

	assign out_rate = out_rate_q;
	assign out_duty = out_duty_q;

	`ASSERT_IMP(a_rem_below_sum, clk, arst_n, cmd.div_step, rem_q < sum_q)
	`ASSERT_NXT(a_edge_clears_silence, clk, arst_n, edge_load, silence_ticks_q == '0)
	`ASSERT_NXT(a_phase_within_limit, clk, arst_n, tick_load, phase_ticks_q <= $past(cfg.phase_limit))

endmodule

[design/pwm_duty_and_pulse_rate_meter.sv]
// ----------------------------------------------------------------------------
// pwm_duty_and_pulse_rate_meter
// pulse rate and duty cycle meter driven by tick and edge transactions
// ----------------------------------------------------------------------------
// Each input transaction (a timer tick or a signal edge) yields exactly one
// output transaction carrying the latched pulse rate and duty value. Ticks,
// rising edges and all edges in pulse mode are applied when taken, then the
// output register is loaded once free. A falling edge in cycle mode runs a
// 16x11 multiply, a divider seed step, 11 steps of the restoring divider and
// the offset/clamp step; a zero phase sum skips the divide. Only one item is
// in flight at a time; the output register lets a new item be taken while
// the previous result waits on m_axis_tready.
// ----------------------------------------------------------------------------
module pwm_duty_and_pulse_rate_meter (
	input  logic                             clk,
	input  logic                             arst_n,
	// input stream
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [pdrm_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [0] pin_level
	input  logic                             s_axis_tuser,  // [0] cmd
	// output stream
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [pdrm_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // [15:0] pulse_rate, [26:16] duty_value
	// configuration
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [pdrm_pkg::PADDR_W-1:0]     paddr,
	input  logic [pdrm_pkg::PDATA_W-1:0]     pwdata,
	output logic [pdrm_pkg::PDATA_W-1:0]     prdata,
	output logic                             pready
);
	import pdrm_pkg::*;

	cfg_t              cfg;
	ctl_cmd_t          cmd;
	ctl_stat_t         stat;
	logic [RATE_W-1:0] out_rate;
	logic [DUTY_W-1:0] out_duty;

	pdrm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pdrm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	pdrm_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cmd      (cmd),
		.stat     (stat),
		.in_cmd   (s_axis_tuser),
		.in_level (s_axis_tdata[0]),
		.out_rate (out_rate),
		.out_duty (out_duty)
	);

	// pack result fields, zero fill to the byte boundary
	assign m_axis_tdata = {{(OUT_TDATA_W-RATE_W-DUTY_W){1'b0}}, out_duty, out_rate};

endmodule

[tb/tb_pwm_duty_and_pulse_rate_meter.sv]
// ----------------------------------------------------------------------------
// tb_pwm_duty_and_pulse_rate_meter
// self-checking bench for the pulse rate and duty cycle meter
// ----------------------------------------------------------------------------
// Tick and edge transactions go in on the input stream. Every accepted one is
// run through a cycle-free model of the meter kept in this bench, and the
// reading it yields is queued. Each reading that comes out is checked field
// by field against the oldest queued one. A short scripted sequence covers
// the corners (zero phase sum, clamp below the offset, phase overrun, silence
// timeout, window latch in cycle mode), then random phases with varied
// register settings follow. Both streams stall at random, except in one phase.
// ----------------------------------------------------------------------------
module tb_pwm_duty_and_pulse_rate_meter;
	timeunit 1ns;
	timeprecision 1ps;

	import pdrm_pkg::*;

	// register slots past the last one, writes there are dropped
	localparam logic [2:0] REG_RSVD6 = 3'd6;
	localparam logic [2:0] REG_RSVD7 = 3'd7;

	localparam int IDLE_PCT       = 31;
	localparam int SETTLE_CYCLES  = 24;
	localparam int TAIL_CYCLES    = 40;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int REPORT_MAX     = 10;
	localparam int RANDOM_ITEMS   = 665;
	localparam int N_PHASES       = 7;
	localparam int SCRIPT_LEN     = 39;

	typedef enum logic {
		ROW_WRITE,
		ROW_ITEM
	} row_kind_t;

	typedef struct packed {
		row_kind_t         kind;
		logic [2:0]        idx;
		logic [31:0]       value;
		logic              cmd;
		logic              level;
		logic              typed;
		logic [RATE_W-1:0] rate;
		logic [DUTY_W-1:0] duty;
	} script_row_t;

	typedef struct packed {
		logic [RATE_W-1:0] rate;
		logic [DUTY_W-1:0] duty;
	} reading_t;

	// scripted corners, readings typed in only where obvious
	localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
		'{ROW_ITEM,  REG_MODE,    32'd0,    ITEM_TICK, 1'b0, 1'b1, 16'd0, 11'd0},
		'{ROW_ITEM,  REG_MODE,    32'd0,    ITEM_EDGE, 1'b1, 1'b1, 16'd0, 11'd0},
		'{ROW_ITEM,  REG_MODE,    32'd0,    ITEM_EDGE, 1'b0, 1'b1, 16'd0, 11'd0},
		'{ROW_WRITE, REG_WINDOW,  32'd1,    ITEM_TICK, 1'b0, 1'b0, 16'd0, 11'd0},
		'{ROW_ITEM,  REG_MODE,    32'd0,    ITEM_TICK, 1'b0, 1'b1, 16'd2, 11'd0},
		'{ROW_WRITE, REG_MODE,    32'd1,    ITEM_TICK, 1'b0, 1'b0, 16'd0, 11'd0},
		'{ROW_WRITE, REG_SCALE,   32'd2047, ITEM_TICK, 1'b0, 1'b0, 16'd0, 11'd0},
		'{ROW_WRITE, REG_OFFSET,  32'd0,    ITEM_TICK, 1'b0, 1'b0, 16'd0, 11'd0},
		// full scale duty, then a zero phase sum holds it
		'{ROW_ITEM,  REG_MODE,    32'd0,    ITEM_EDGE, 1'b0, 1'b1, 16'd2, 11'd2047},
		'{ROW_ITEM,  REG_MODE,    32'd0,    ITEM_EDGE, 1'b1, 1'b0, 16'd0, 11'd0},
		'{ROW_ITEM,  REG_MODE,    32'd0,    ITEM_EDGE, 1'b0, 1'b1, 16'd2, 11'd2047},
		// window closes in cycle mode with no counted edges
		'{ROW_ITEM,  REG_MODE,    32'd0,    ITEM_TICK, 1'b0, 1'b1, 16'd0, 11'd2047},
		'{ROW_WRITE, REG_OFFSET,  32'd255,  ITEM_TICK, 1'b0, 1'b0, 16'd0, 11'd0},
		'{ROW_ITEM,  REG_MODE,    32'd0,    ITEM_EDGE, 1'b1, 1'b0, 16'd0, 11'd0},
		'{ROW_ITEM,  REG_MODE,    32'd0,    ITEM_TICK, 1'b0, 1'b0, 16'd0, 11'd0},
		'{ROW_ITEM,  REG_MODE,    32'd0,    ITEM_EDGE, 1'b0, 1'b0, 16'd0, 11'd0},
		// phase overrun clears the duty value
		'{ROW_WRITE, REG_PHASE,   32'd1,    ITEM_TICK, 1'b0, 1'b0, 16'd0, 11'd0},
		'{ROW_ITEM,  REG_MODE,    32'd0,    ITEM_TICK, 1'b0, 1'b0, 16'd0, 11'd0},
		'{ROW_ITEM,  REG_MODE,    32'd0,    ITEM_TICK, 1'b0, 1'b1, 16'd0, 11'd0},
		'{ROW_ITEM,  REG_MODE,    32'd0,    ITEM_EDGE, 1'b1, 1'b0, 16'd0, 11'd0},
		'{ROW_ITEM,  REG_MODE,    32'd0,    ITEM_TICK, 1'b0, 1'b0, 16'd0, 11'd0},
		'{ROW_ITEM,  REG_MODE,    32'd0,    ITEM_EDGE, 1'b0, 1'b0, 16'd0, 11'd0},
		'{ROW_ITEM,  REG_MODE,    32'd0,    ITEM_EDGE, 1'b1, 1'b0, 16'd0, 11'd0},
		'{ROW_ITEM,  REG_MODE,    32'd0,    ITEM_EDGE, 1'b0, 1'b0, 16'd0, 11'd0},
		// scaled duty below the offset clamps at zero
		'{ROW_WRITE, REG_SCALE,   32'd1,    ITEM_TICK, 1'b0, 1'b0, 16'd0, 11'd0},
		'{ROW_ITEM,  REG_MODE,    32'd0,    ITEM_EDGE, 1'b1, 1'b0, 16'd0, 11'd0},
		'{ROW_ITEM,  REG_MODE,    32'd0,    ITEM_TICK, 1'b0, 1'b0, 16'd0, 11'd0},
		'{ROW_ITEM,  REG_MODE,    32'd0,    ITEM_EDGE, 1'b0, 1'b1, 16'd0, 11'd0},
		// pulse mode, silence timeout clears the rate
		'{ROW_WRITE, REG_MODE,    32'd0,    ITEM_TICK, 1'b0, 1'b0, 16'd0, 11'd0},
		'{ROW_WRITE, REG_WINDOW,  32'd3,    ITEM_TICK, 1'b0, 1'b0, 16'd0, 11'd0},
		'{ROW_WRITE, REG_SILENCE, 32'd1,    ITEM_TICK, 1'b0, 1'b0, 16'd0, 11'd0},
		'{ROW_WRITE, REG_RSVD6,   32'hFFFF_FFFF, ITEM_TICK, 1'b0, 1'b0, 16'd0, 11'd0},
		'{ROW_WRITE, REG_RSVD7,   32'hFFFF_FFFF, ITEM_TICK, 1'b0, 1'b0, 16'd0, 11'd0},
		'{ROW_ITEM,  REG_MODE,    32'd0,    ITEM_EDGE, 1'b1, 1'b0, 16'd0, 11'd0},
		'{ROW_ITEM,  REG_MODE,    32'd0,    ITEM_EDGE, 1'b0, 1'b0, 16'd0, 11'd0},
		'{ROW_ITEM,  REG_MODE,    32'd0,    ITEM_TICK, 1'b0, 1'b0, 16'd0, 11'd0},
		'{ROW_ITEM,  REG_MODE,    32'd0,    ITEM_TICK, 1'b0, 1'b0, 16'd0, 11'd0},
		'{ROW_ITEM,  REG_MODE,    32'd0,    ITEM_TICK, 1'b0, 1'b1, 16'd2, 11'd0},
		'{ROW_ITEM,  REG_MODE,    32'd0,    ITEM_TICK, 1'b0, 1'b1, 16'd0, 11'd0}
	};

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   s_axis_tuser = 1'b0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   psel = 1'b0;
	logic                   penable = 1'b0;
	logic                   pwrite = 1'b0;
	logic [PADDR_W-1:0]     paddr = '0;
	logic [PDATA_W-1:0]     pwdata = '0;
	logic [PDATA_W-1:0]     prdata;
	logic                   pready;

	// meter model state and register mirror
	cfg_t              meter_cfg;
	logic [CNT_W-1:0]  m_phase;
	logic [CNT_W-1:0]  m_silence;
	logic [CNT_W-1:0]  m_window;
	logic [RATE_W-1:0] m_edges;
	logic [CNT_W-1:0]  m_low;
	logic [CNT_W-1:0]  m_high;
	logic [RATE_W-1:0] m_rate;
	logic [DUTY_W-1:0] m_duty;

	reading_t readings_due [$];

	bit in_idle_on  = 1'b1;
	bit out_idle_on = 1'b1;
	int fail_cnt = 0;
	int stall_cycles = 0;
	int n_items = 0;
	int n_checked = 0;
	int n_writes = 0;
	int n_ticks = 0;
	int n_edges = 0;
	int n_duty_calc = 0;
	int n_clamped = 0;
	int n_zero_sum = 0;
	int n_phase_clear = 0;
	int n_silence_clear = 0;
	int n_saturated = 0;

	pwm_duty_and_pulse_rate_meter dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),  // [0] pin_level
		.s_axis_tuser  (s_axis_tuser),  // [0] cmd
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),  // [15:0] pulse_rate, [26:16] duty_value
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic report(input string msg);
		fail_cnt++;
		if (fail_cnt <= REPORT_MAX)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	// advance the meter model by one transaction, return the reading it gives
	function automatic reading_t meter_update(input logic cmd, input logic level);
		logic [SUM_W-1:0] sum;
		longint unsigned  quo;
		reading_t         r;
		if (cmd == ITEM_TICK) begin
			n_ticks++;
			m_phase = m_phase + 1'b1;
			if (m_phase > meter_cfg.phase_limit) begin
				m_phase = '0;
				m_duty = '0;
				n_phase_clear++;
			end
			m_silence = m_silence + 1'b1;
			if (m_silence > meter_cfg.silence_limit) begin
				m_silence = '0;
				m_duty = '0;
				m_rate = '0;
				n_silence_clear++;
			end
			m_window = m_window + 1'b1;
			if (m_window >= meter_cfg.window_ticks) begin
				m_rate = m_edges;
				m_edges = '0;
				m_window = '0;
			end
		end else begin
			n_edges++;
			m_silence = '0;
			if (meter_cfg.measure_mode == MODE_PULSE) begin
				if (m_edges != '1)
					m_edges = m_edges + 1'b1;
				else
					n_saturated++;
			end else if (level) begin
				m_low = m_phase;
				m_phase = '0;
			end else begin
				m_high = m_phase;
				m_phase = '0;
				sum = SUM_W'(m_high) + SUM_W'(m_low);
				if (sum == '0) begin
					n_zero_sum++;
				end else begin
					n_duty_calc++;
					quo = (64'(m_high) * 64'(meter_cfg.duty_scale)) / 64'(sum);
					if (quo > 64'(meter_cfg.duty_offset)) begin
						m_duty = DUTY_W'(quo - 64'(meter_cfg.duty_offset));
					end else begin
						m_duty = '0;
						n_clamped++;
					end
				end
			end
		end
		r.rate = m_rate;
		r.duty = m_duty;
		return r;
	endfunction

	// one input transaction; a typed reading overrides the model's
	task automatic send_item(input logic cmd, input logic level, input logic typed,
			input reading_t given);
		reading_t r;
		while (in_idle_on && $urandom_range(99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= IN_TDATA_W'(level);
		do @(posedge clk); while (!s_axis_tready);
		r = meter_update(cmd, level);
		readings_due.push_back(typed ? given : r);
		n_items++;
	endtask

	// stop sending and let every pending reading come out
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (readings_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register write, then read back where the slot exists
	task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
		logic [31:0] held;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		n_writes++;
		held = '0;
		case (idx)
			REG_MODE:    meter_cfg.measure_mode = value[0];
			REG_PHASE:   meter_cfg.phase_limit = value[LIMIT_W-1:0];
			REG_SILENCE: meter_cfg.silence_limit = value[LIMIT_W-1:0];
			REG_WINDOW:  meter_cfg.window_ticks = value[LIMIT_W-1:0];
			REG_SCALE:   meter_cfg.duty_scale = value[SCALE_W-1:0];
			REG_OFFSET:  meter_cfg.duty_offset = value[OFS_W-1:0];
			default: ;
		endcase
		case (idx)
			REG_MODE:    held = 32'(meter_cfg.measure_mode);
			REG_PHASE:   held = 32'(meter_cfg.phase_limit);
			REG_SILENCE: held = 32'(meter_cfg.silence_limit);
			REG_WINDOW:  held = 32'(meter_cfg.window_ticks);
			REG_SCALE:   held = 32'(meter_cfg.duty_scale);
			REG_OFFSET:  held = 32'(meter_cfg.duty_offset);
			default: ;
		endcase
		if (idx <= REG_OFFSET) begin
			penable <= 1'b0;
			pwrite <= 1'b0;
			@(posedge clk);
			penable <= 1'b1;
			do @(posedge clk); while (!pready);
			if (prdata != held)
				report($sformatf("register %0d read back: expected %0d, got %0d",
					idx, held, prdata));
		end
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// limit picker weighted toward the extremes and short timeouts
	function automatic logic [15:0] pick_limit();
		case ($urandom_range(7))
			0: return 16'd0;
			1: return 16'd1;
			2: return 16'hFFFF;
			3: return 16'hFFFE;
			default: return 16'($urandom_range(40, 2));
		endcase
	endfunction

	// output side readiness
	always @(posedge clk)
		m_axis_tready <= !(out_idle_on && $urandom_range(99) < IDLE_PCT);

	// compare each output transaction with the oldest pending reading
	always @(posedge clk) begin : check_output
		reading_t got;
		reading_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.rate = m_axis_tdata[RATE_W-1:0];
			got.duty = m_axis_tdata[RATE_W +: DUTY_W];
			n_checked++;
			if (readings_due.size() == 0) begin
				report($sformatf("reading with none pending: rate %0d duty %0d",
					got.rate, got.duty));
			end else begin
				want = readings_due.pop_front();
				if (got.rate != want.rate)
					report($sformatf("pulse_rate: expected %0d, got %0d",
						want.rate, got.rate));
				if (got.duty != want.duty)
					report($sformatf("duty_value: expected %0d, got %0d",
						want.duty, got.duty));
			end
		end
	end

	// watchdog on cycles with no transaction anywhere
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
			$display("status: fail");
			$finish;
		end
	end

	initial begin : stimulus
		logic [31:0] vals [6];
		logic        level;
		int          n;
		int          gap;

		// model state after reset
		meter_cfg.measure_mode = MODE_PULSE;
		meter_cfg.phase_limit = PHASE_LIMIT_RST;
		meter_cfg.silence_limit = SILENCE_LIMIT_RST;
		meter_cfg.window_ticks = WINDOW_TICKS_RST;
		meter_cfg.duty_scale = DUTY_SCALE_RST;
		meter_cfg.duty_offset = DUTY_OFFSET_RST;
		m_phase = '0;
		m_silence = '0;
		m_window = '0;
		m_edges = '0;
		m_low = '0;
		m_high = '0;
		m_rate = '0;
		m_duty = '0;
		level = 1'b0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// scripted corners
		for (int i = 0; i < SCRIPT_LEN; i++) begin
			if (SCRIPT[i].kind == ROW_WRITE) begin
				wait_idle();
				reg_write(SCRIPT[i].idx, SCRIPT[i].value);
			end else begin
				send_item(SCRIPT[i].cmd, SCRIPT[i].level, SCRIPT[i].typed,
					{SCRIPT[i].rate, SCRIPT[i].duty});
			end
		end

		// random phases: low extremes, high extremes, zeros, then random settings
		for (int p = 0; p < N_PHASES; p++) begin
			wait_idle();
			case (p)
				0: vals = '{32'(MODE_PULSE), 32'd1, 32'd1, 32'd1, 32'd1, 32'd0};
				1: vals = '{32'(MODE_CYCLE), 32'd65534, 32'd65534, 32'd65535,
					32'd2047, 32'd255};
				2: vals = '{32'(MODE_CYCLE), 32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
				default: begin
					vals[0] = 32'($urandom_range(3) != 0);
					vals[1] = 32'(pick_limit());
					vals[2] = 32'(pick_limit());
					vals[3] = 32'(pick_limit());
					vals[4] = ($urandom_range(3) == 0) ? 32'd2047 : 32'($urandom_range(2047));
					vals[5] = 32'($urandom_range(255));
				end
			endcase
			for (int r = 0; r < 6; r++)
				reg_write(3'(r), vals[r]);
			in_idle_on = (p != 3);
			out_idle_on = (p != 3);
			n = 0;
			while (n < RANDOM_ITEMS / N_PHASES) begin
				if ($urandom_range(99) < 80) begin
					// a run of ticks then the next edge of a well-formed waveform
					gap = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(6);
					repeat (gap) send_item(ITEM_TICK, 1'($urandom_range(1)), 1'b0, '0);
					level = ~level;
					send_item(ITEM_EDGE, level, 1'b0, '0);
					n += gap + 1;
				end else begin
					send_item(1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0, '0);
					n++;
				end
			end
		end

		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (readings_due.size() != 0)
			report($sformatf("%0d readings never arrived", readings_due.size()));

		$display("covered %0d transactions (%0d ticks, %0d edges), %0d writes, %0d checked",
			n_items, n_ticks, n_edges, n_writes, n_checked);
		$display("%0d duty calcs (%0d clamped, %0d zero sum), %0d overruns, %0d timeouts",
			n_duty_calc, n_clamped, n_zero_sum, n_phase_clear, n_silence_clear);
		if (fail_cnt == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
